// ----- src/swsbr_pkg.sv -----
// Package for the single-wire sensor byte reader: transaction types, register
// indexes, phase/status/drive codes and sizing constants.
// No dependencies.
package swsbr_pkg;

    // Bits assembled per read
    localparam int BITS_PER_READ = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_READ + 1);

    // Configuration port sizing
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Tick counter width and its one-bit-wider increment
    localparam int TICK_W = 16;
    localparam int INC_W  = TICK_W + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH   = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_START_LOW    = 16'd18000;
    localparam logic [7:0]  RST_RELEASE_HIGH = 8'd30;
    localparam logic [7:0]  RST_SETTLE       = 8'd5;
    localparam logic [7:0]  RST_RESP_LIMIT   = 8'd100;
    localparam logic [7:0]  RST_ONE_THRESH   = 8'd40;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_LOW       = 4'd1,
        PH_HIGH      = 4'd2,
        PH_SETTLE    = 4'd3,
        PH_RESP_LOW  = 4'd4,
        PH_RESP_HIGH = 4'd5,
        PH_WAIT_BIT  = 4'd6,
        PH_MEASURE   = 4'd7,
        PH_GAP       = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_READY = 2'd2,
        ST_NORSP = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DRV_RELEASE = 2'd0,
        DRV_LOW     = 2'd1,
        DRV_HIGH    = 2'd2
    } drive_t;

    typedef struct packed {
        logic mode;
        logic line_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0] line_drive;
        logic [7:0] received_byte;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_high_ticks;
        logic [7:0]  settle_ticks;
        logic [7:0]  response_limit;
        logic [7:0]  one_threshold;
    } cfg_t;

endpackage

// ----- src/single_wire_sensor_byte_reader_core.sv -----
// Single-wire sensor byte reader: one microsecond tick per input transaction.
// Data path: an accepted tick lands in the input register, and its result is
// loaded into the result register once that register is empty or being taken.
// Throughput: one tick per cycle while m_ready does not stall the result register.
// Reset: synchronous active-low aresetn returns to idle and reloads registers.
module single_wire_sensor_byte_reader_core
    import swsbr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      step_en;
    out_item_t result;
    cfg_t      cfg;

    assign cfg_ready = 1'b1;

    swsbr_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Process the held tick whenever the result register can take it
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    swsbr_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Hold the incoming transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Result register: load on step, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // A start request always drives the line low on its own tick
    a_start_drives_low: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && in_item_reg.mode |-> result.line_drive == DRV_LOW)
        else $error("start tick does not drive the line low");

    // The byte field is zero unless a byte is reported
    a_byte_only_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_READY) |-> m_data.received_byte == 8'd0)
        else $error("received byte set without byte_ready");

    // An empty result register never stalls the input
    a_no_needless_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    // A held tick that is not processed stays in the input register
    a_held_tick_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step_en |=> in_valid_reg && $stable(in_item_reg))
        else $error("unprocessed tick lost from input register");

endmodule

// ----- src/swsbr_cfg.sv -----
// Configuration register file of the single-wire sensor byte reader.
// Depends on swsbr_pkg.
module swsbr_cfg
    import swsbr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Write the addressed register; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks    <= RST_START_LOW;
            cfg_reg.release_high_ticks <= RST_RELEASE_HIGH;
            cfg_reg.settle_ticks       <= RST_SETTLE;
            cfg_reg.response_limit     <= RST_RESP_LIMIT;
            cfg_reg.one_threshold      <= RST_ONE_THRESH;
        end else if (wr_en) begin
            unique case (wr_index)
                CFG_START_LOW:    cfg_reg.start_low_ticks    <= wr_data;
                CFG_RELEASE_HIGH: cfg_reg.release_high_ticks <= wr_data[7:0];
                CFG_SETTLE:       cfg_reg.settle_ticks       <= wr_data[7:0];
                CFG_RESP_LIMIT:   cfg_reg.response_limit     <= wr_data[7:0];
                CFG_ONE_THRESH:   cfg_reg.one_threshold      <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/swsbr_engine.sv -----
// Per-tick state machine of the single-wire sensor byte reader: phase, tick
// counter, bit index and shift register, plus the result of the current tick.
// Depends on swsbr_pkg.
module swsbr_engine
    import swsbr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    phase_t                phase_reg,  phase_next;
    logic [TICK_W-1:0]     tick_reg,   tick_next;
    logic [BIT_IDX_W-1:0]  bit_reg,    bit_next;
    logic [7:0]            shift_reg,  shift_next;

    // State after a start request has been applied
    phase_t                ph;
    logic [TICK_W-1:0]     tc;
    logic [BIT_IDX_W-1:0]  bi;
    logic [7:0]            sb;
    logic [INC_W-1:0]      tick_inc;
    logic                  do_finish;
    logic                  do_end_gap;
    logic [INC_W-1:0]      fin_count;
    logic                  bit_val;
    drive_t                drive;
    status_t               status;

    // Advance the state once per processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
        end
    end

    // Next state and result of one tick
    always_comb begin
        ph = phase_reg;
        tc = tick_reg;
        bi = bit_reg;
        sb = shift_reg;
        if (item.mode) begin
            ph = PH_LOW;
            tc = '0;
            bi = '0;
            sb = '0;
        end

        tick_inc   = {1'b0, tc} + INC_W'(1);
        phase_next = ph;
        tick_next  = tc;
        bit_next   = bi;
        shift_next = sb;
        drive      = DRV_RELEASE;
        status     = ST_BUSY;
        do_finish  = 1'b0;
        do_end_gap = 1'b0;
        fin_count  = '0;
        bit_val    = 1'b0;

        unique case (ph)
            PH_LOW: begin
                drive     = DRV_LOW;
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= INC_W'(cfg.start_low_ticks)) begin
                    tick_next = '0;
                    if (cfg.release_high_ticks != 8'd0) begin
                        phase_next = PH_HIGH;
                    end else if (cfg.settle_ticks != 8'd0) begin
                        phase_next = PH_SETTLE;
                    end else begin
                        phase_next = PH_RESP_LOW;
                    end
                end
            end
            PH_HIGH: begin
                drive     = DRV_HIGH;
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= INC_W'(cfg.release_high_ticks)) begin
                    tick_next  = '0;
                    phase_next = (cfg.settle_ticks != 8'd0) ? PH_SETTLE : PH_RESP_LOW;
                end
            end
            PH_SETTLE: begin
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= INC_W'(cfg.settle_ticks)) begin
                    tick_next  = '0;
                    phase_next = PH_RESP_LOW;
                end
            end
            PH_RESP_LOW: begin
                if (item.line_level) begin
                    tick_next  = '0;
                    phase_next = PH_RESP_HIGH;
                end else begin
                    tick_next = tick_inc[TICK_W-1:0];
                    if (tick_inc >= INC_W'(cfg.response_limit)) begin
                        tick_next  = '0;
                        phase_next = PH_IDLE;
                        status     = ST_NORSP;
                    end
                end
            end
            PH_RESP_HIGH: begin
                if (!item.line_level) begin
                    tick_next  = '0;
                    bit_next   = '0;
                    shift_next = '0;
                    phase_next = PH_WAIT_BIT;
                end else begin
                    tick_next = tick_inc[TICK_W-1:0];
                    if (tick_inc >= INC_W'(cfg.response_limit)) begin
                        tick_next  = '0;
                        phase_next = PH_IDLE;
                        status     = ST_NORSP;
                    end
                end
            end
            PH_WAIT_BIT: begin
                // No timeout here: only a start request leaves a hung bit
                if (item.line_level) begin
                    tick_next = '0;
                    if (cfg.response_limit == 8'd0) begin
                        do_finish = 1'b1;
                    end else begin
                        phase_next = PH_MEASURE;
                    end
                end
            end
            PH_MEASURE: begin
                if (item.line_level) begin
                    tick_next = tick_inc[TICK_W-1:0];
                    if (tick_inc >= INC_W'(cfg.response_limit)) begin
                        do_finish = 1'b1;
                        fin_count = tick_inc;
                    end
                end else begin
                    do_finish = 1'b1;
                    fin_count = {1'b0, tc};
                end
            end
            PH_GAP: begin
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= INC_W'(cfg.settle_ticks)) begin
                    do_end_gap = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
                status     = ST_IDLE;
            end
        endcase

        // Decode the pulse and shift the bit in
        if (do_finish) begin
            bit_val    = (fin_count > INC_W'(cfg.one_threshold));
            shift_next = {sb[6:0], bit_val};
            tick_next  = '0;
            if (cfg.settle_ticks == 8'd0) begin
                do_end_gap = 1'b1;
            end else begin
                phase_next = PH_GAP;
            end
        end

        // Close the bit: next bit or byte complete
        if (do_end_gap) begin
            tick_next = '0;
            if (bi >= BIT_IDX_W'(BITS_PER_READ - 1)) begin
                phase_next = PH_IDLE;
                status     = ST_READY;
            end else begin
                bit_next   = bi + BIT_IDX_W'(1);
                phase_next = PH_WAIT_BIT;
            end
        end

        result.line_drive    = drive;
        result.received_byte = (status == ST_READY) ? shift_next : 8'd0;
        result.status        = status;
    end

endmodule
